// File: rtl/icmp_rfe_pkg.sv
package icmp_rfe_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 65535;

	localparam int WORD_BYTES = 4;
	localparam int QUOTE_SKIP = 8;

	// ICMP type codes
	localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
	localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

	// result kinds
	localparam logic [1:0] KIND_ECHO_REPLY    = 2'd0;
	localparam logic [1:0] KIND_TIME_EXCEEDED = 2'd1;
	localparam logic [1:0] KIND_UNEXPECTED    = 2'd2;

	// configuration register byte addresses
	localparam logic [2:0] ADDR_EXPECTED_SEQ = 3'd0;

	localparam int OUT_DATA_W = 40;

	typedef struct packed {
		logic [1:0]  packet_kind;
		logic [15:0] ident;
		logic [15:0] sequence_res;
		logic        seq_match;
		logic        truncated;
	} rfe_result_t;

endpackage

// File: rtl/icmp_rfe_cfg.sv
module icmp_rfe_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] expected_seq
);

	logic [15:0] expected_seq_q;
	logic        sel_seq;

	// decode on the word index; byte-lane bits are don't care
	assign sel_seq = (paddr[2] == icmp_rfe_pkg::ADDR_EXPECTED_SEQ[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_seq_q <= 16'd1;
		end else if (psel && penable && pwrite && pready && sel_seq) begin
			expected_seq_q <= pwdata[15:0];
		end
	end

	assign prdata       = sel_seq ? {16'd0, expected_seq_q} : 32'd0;
	assign expected_seq = expected_seq_q;

endmodule

// File: rtl/icmp_rfe_core.sv
module icmp_rfe_core #(
	parameter int MAX_PACKET_BYTES = icmp_rfe_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	input  logic [15:0]               expected_seq,
	output logic                      res_valid,
	output icmp_rfe_pkg::rfe_result_t res
);

	localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CW   = (PosW > 9) ? PosW : 9;

	logic [PosW-1:0] pos_q, pos_d;
	logic [5:0]      start_q, start_d;
	logic [7:0]      inner_q, inner_d;
	logic [7:0]      type_q, type_d;
	logic [15:0]     ident_q, ident_d;
	logic [15:0]     seq_q, seq_d;
	logic            fc_q, fc_d;

	logic [CW-1:0]   pos_w, start_w, base_w, inner_sum;
	logic            active, after_type, is_echo, is_te, take, quote_hdr, type_seen;

	always_comb begin
		active  = pos_q < PosW'(MAX_PACKET_BYTES);
		start_d = (pos_q == '0) ? {data_byte[3:0], 2'b00} : start_q;
		pos_w   = CW'(pos_q);
		start_w = CW'(start_d);
		type_d  = (active && pos_w == start_w) ? data_byte : type_q;
		if (!active) start_d = start_q;

		is_echo    = (type_q == icmp_rfe_pkg::TYPE_ECHO_REPLY);
		is_te      = (type_q == icmp_rfe_pkg::TYPE_TIME_EXCEEDED);
		after_type = active && (pos_w > start_w) && !fc_q;
		quote_hdr  = after_type && is_te && (pos_w == start_w + CW'(icmp_rfe_pkg::QUOTE_SKIP));
		take       = after_type && (is_echo ||
			(is_te && pos_w > start_w + CW'(icmp_rfe_pkg::QUOTE_SKIP)));
		base_w     = is_echo ? start_w : CW'(inner_q);

		// inner header offset: at most 68 + 60, fits eight bits
		inner_sum = pos_w + CW'({data_byte[3:0], 2'b00});
		inner_d   = quote_hdr ? inner_sum[7:0] : inner_q;

		ident_d = ident_q;
		seq_d   = seq_q;
		fc_d    = fc_q;
		if (take) begin
			if (pos_w == base_w + CW'(4)) begin
				ident_d[7:0] = data_byte;
			end else if (pos_w == base_w + CW'(5)) begin
				ident_d[15:8] = data_byte;
			end else if (pos_w == base_w + CW'(6)) begin
				seq_d[7:0] = data_byte;
			end else if (pos_w == base_w + CW'(7)) begin
				seq_d[15:8] = data_byte;
				fc_d = 1'b1;
			end
		end

		pos_d = active ? pos_q + PosW'(1) : pos_q;

		// result, built from the state as updated by this item
		type_seen        = CW'(pos_d) > start_w;
		res              = '0;
		res.packet_kind  = icmp_rfe_pkg::KIND_UNEXPECTED;
		if (!type_seen) begin
			res.truncated = 1'b1;
		end else if (type_d == icmp_rfe_pkg::TYPE_ECHO_REPLY ||
			type_d == icmp_rfe_pkg::TYPE_TIME_EXCEEDED) begin
			res.packet_kind = (type_d == icmp_rfe_pkg::TYPE_ECHO_REPLY) ?
				icmp_rfe_pkg::KIND_ECHO_REPLY : icmp_rfe_pkg::KIND_TIME_EXCEEDED;
			if (fc_d) begin
				res.ident        = ident_d;
				res.sequence_res = seq_d;
				res.seq_match    = (seq_d == expected_seq);
			end else begin
				res.truncated = 1'b1;
			end
		end
	end

	assign res_valid = en && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			inner_q <= '0;
			type_q  <= '0;
			ident_q <= '0;
			seq_q   <= '0;
			fc_q    <= 1'b0;
		end else if (en) begin
			if (last_byte) begin
				pos_q   <= '0;
				start_q <= '0;
				inner_q <= '0;
				type_q  <= '0;
				ident_q <= '0;
				seq_q   <= '0;
				fc_q    <= 1'b0;
			end else begin
				pos_q   <= pos_d;
				start_q <= start_d;
				inner_q <= inner_d;
				type_q  <= type_d;
				ident_q <= ident_d;
				seq_q   <= seq_d;
				fc_q    <= fc_d;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		en && last_byte |=> pos_q == '0 && !fc_q)
		else $error("packet state not cleared after last byte");

	a_fields_need_known_type: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q |-> (type_q == icmp_rfe_pkg::TYPE_ECHO_REPLY ||
			type_q == icmp_rfe_pkg::TYPE_TIME_EXCEEDED))
		else $error("fields complete on unexpected ICMP type");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosW'(MAX_PACKET_BYTES))
		else $error("byte position past saturation limit");

endmodule

// File: rtl/icmp_reply_field_extractor.sv
// ICMP reply field extractor: takes one received IPv4 packet a byte per item on the
// s_ side (tdata = byte, tlast on the final byte) and returns one result item per
// packet on the m_ side, from an output register loaded as the core takes the final
// byte. It accepts a byte every cycle; the only stall is a finished result still
// held in the output register, blocking the next final byte. Per-packet state is
// one set of offset registers updated by compares with the running byte position,
// which saturates at MAX_PACKET_BYTES. expected_seq is at APB address 0 (reset 1).
module icmp_reply_field_extractor #(
	parameter int MAX_PACKET_BYTES = icmp_rfe_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [icmp_rfe_pkg::OUT_DATA_W-1:0] m_tdata,
	// [15:0] ident, [31:16] sequence_res, [32] seq_match, [33] truncated, [39:34] zero
	output logic [1:0]  m_tuser,  // [1:0] packet_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                      valid_s1;
	logic [7:0]                data_s1;
	logic                      last_s1;
	logic                      valid_s2;
	icmp_rfe_pkg::rfe_result_t res_s2;
	icmp_rfe_pkg::rfe_result_t res;
	logic                      res_valid;
	logic                      en;
	logic [15:0]               expected_seq;

	icmp_rfe_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.expected_seq (expected_seq)
	);

	// a non-final byte never needs the output register
	assign en       = valid_s1 && (!last_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	icmp_rfe_core #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.data_byte    (data_s1),
		.last_byte    (last_s1),
		.expected_seq (expected_seq),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.packet_kind;
	assign m_tdata  = {6'd0, res_s2.truncated, res_s2.seq_match,
		res_s2.sequence_res, res_s2.ident};

	a_trunc_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.truncated && res_s2.seq_match))
		else $error("truncated result flagged as sequence match");

	a_match_known_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.seq_match |->
		res_s2.packet_kind != icmp_rfe_pkg::KIND_UNEXPECTED)
		else $error("sequence match on unexpected kind");

endmodule
